// ===== rtl/ptst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the periodic timer slot table.
package ptst_pkg;

   localparam int unsigned SLOTS_DEFAULT  = 16;
   localparam int unsigned SLOT_W         = 4;
   localparam int unsigned TAG_W          = 8;
   localparam int unsigned HANDLER_W      = 8;
   localparam int unsigned PERIOD_W       = 16;
   localparam int unsigned REPORT_W       = 5;
   localparam logic [REPORT_W-1:0] REPORT_MAX = 5'd16;
   localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD_RESET = 16'd60;
   localparam logic [TAG_W-1:0]    FREED_TAG = 8'hFF;
   localparam int unsigned REQ_DATA_W     = 40;
   localparam int unsigned RSP_DATA_W     = 24;

   typedef enum logic [1:0] {
      FUNC_REGISTER   = 2'd0,
      FUNC_UNREGISTER = 2'd1,
      FUNC_TICK       = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      KIND_REGISTERED   = 3'd0,
      KIND_FULL         = 3'd1,
      KIND_UNREGISTERED = 3'd2,
      KIND_NO_MATCH     = 3'd3,
      KIND_EXPIRY       = 3'd4,
      KIND_NO_EXPIRY    = 3'd5
   } kind_type;

   // A request travelling down the chain of slot cells.
   typedef struct packed {
      logic                  valid;
      func_type              func;
      logic [TAG_W-1:0]      tag;
      logic [HANDLER_W-1:0]  handler;
      logic [PERIOD_W-1:0]   period;
      logic                  done;
      logic [REPORT_W-1:0]   reported;
   } token_type;

   typedef struct packed {
      kind_type              kind;
      logic [SLOT_W-1:0]     slot;
      logic [TAG_W-1:0]      tag;
      logic [HANDLER_W-1:0]  handler;
   } result_type;

endpackage

// ===== rtl/periodic_timer_slot_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the periodic timer slot table: request launch, cell chain and result staging.
// Each request walks a chain of SLOTS slot cells, one cell per cycle while the chain is not
// stalled, then one end stage. From acceptance the request passes every slot cell and the
// end stage before its last response is loaded into the output register; the busy flag
// drops in the same cycle, and the next request is taken after that. A response side that
// holds a result back stalls the chain and delays this. The last response of a request may
// still be waiting in the output register when the next request is taken. A request with an
// unused function code is taken and gives no response, and the next request may follow in
// the cycle after it. Register results, unregister results and expiries are produced by
// the cell that owns the slot; a full table, a failed match and a tick without expiry are
// reported at the end of the chain.
module periodic_timer_slot_table_core #(
   parameter int unsigned SLOTS = ptst_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: func[1:0], tag[9:2], handler[17:10], period[33:18], zero fill.
   input  logic [ptst_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: kind[2:0], slot[6:3], out_tag[14:7], out_handler[22:15], zero fill.
   output logic [ptst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wen,
   input  logic [ptst_pkg::PERIOD_W-1:0]     csr_wdata
);

   logic [ptst_pkg::PERIOD_W-1:0] default_period_ff;
   logic busy_ff, busy_in;
   ptst_pkg::token_type  tok_w [SLOTS+1];
   ptst_pkg::token_type  launch;
   ptst_pkg::token_type  tok_end_ff;
   logic                 emit_v [SLOTS];
   ptst_pkg::result_type emit_r [SLOTS];
   logic                 emit_any;
   ptst_pkg::result_type emit_sel;
   logic                 pend_valid_ff, pend_valid_in;
   ptst_pkg::result_type pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   ptst_pkg::result_type out_ff, out_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_free, stall, advance, accept;
   logic [1:0]           req_func;
   logic [ptst_pkg::PERIOD_W-1:0] req_period;
   ptst_pkg::result_type end_res;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign req_func   = req_tdata[1:0];
   assign req_period = req_tdata[33:18];

   always_comb begin
      launch          = '0;
      launch.valid    = accept && (req_func == ptst_pkg::FUNC_REGISTER ||
                                   req_func == ptst_pkg::FUNC_UNREGISTER ||
                                   req_func == ptst_pkg::FUNC_TICK);
      launch.func     = ptst_pkg::func_type'(req_func);
      launch.tag      = req_tdata[9:2];
      launch.handler  = req_tdata[17:10];
      launch.period   = (req_period == '0) ? default_period_ff : req_period;
   end

   assign tok_w[0] = launch;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ptst_cell #(
         .INDEX(g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .tok_prev  (tok_w[g]),
         .tok_next  (tok_w[g+1]),
         .emit_valid(emit_v[g]),
         .emit_res  (emit_r[g])
      );
   end

   // At most one cell holds the request, so the results can be merged by OR.
   always_comb begin
      emit_any = 1'b0;
      emit_sel = '0;
      for (int i = 0; i < SLOTS; i++) begin
         emit_any = emit_any | emit_v[i];
         if (emit_v[i]) begin
            emit_sel = emit_sel | emit_r[i];
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign stall    = !out_free && ((emit_any && pend_valid_ff) || tok_end_ff.valid);
   assign advance  = !stall;

   always_comb begin
      end_res = '0;
      case (tok_end_ff.func)
         ptst_pkg::FUNC_REGISTER:   end_res.kind = ptst_pkg::KIND_FULL;
         ptst_pkg::FUNC_UNREGISTER: end_res.kind = ptst_pkg::KIND_NO_MATCH;
         ptst_pkg::FUNC_TICK:       end_res.kind = ptst_pkg::KIND_NO_EXPIRY;
         default:                   end_res.kind = ptst_pkg::KIND_NO_EXPIRY;
      endcase
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      busy_in       = busy_ff;
      if (accept && launch.valid) begin
         busy_in = 1'b1;
      end
      if (advance) begin
         if (emit_any) begin
            pend_valid_in = 1'b1;
            pend_in       = emit_sel;
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
               out_last_in  = 1'b0;
            end
         end else if (tok_end_ff.valid) begin
            pend_valid_in = 1'b0;
            out_valid_in  = 1'b1;
            out_in        = pend_valid_ff ? pend_ff : end_res;
            out_last_in   = 1'b1;
            busy_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_period_ff <= ptst_pkg::DEFAULT_PERIOD_RESET;
         busy_ff           <= 1'b0;
         tok_end_ff        <= '0;
         pend_valid_ff     <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (csr_wen) begin
            default_period_ff <= csr_wdata;
         end
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (advance) begin
            tok_end_ff <= tok_w[SLOTS];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_ff.handler, out_ff.tag, out_ff.slot, out_ff.kind};

endmodule

// ===== rtl/ptst_cell.sv =====
`timescale 1ns / 1ps
// One timer slot: holds the slot state and acts on the request passing through it.
module ptst_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ptst_pkg::token_type  tok_prev,
   output ptst_pkg::token_type  tok_next,
   output logic                 emit_valid,
   output ptst_pkg::result_type emit_res
);

   ptst_pkg::token_type tok_ff;
   logic active_ff, active_in;
   logic [ptst_pkg::TAG_W-1:0]     tag_ff, tag_in;
   logic [ptst_pkg::HANDLER_W-1:0] handler_ff, handler_in;
   logic [ptst_pkg::PERIOD_W-1:0]  period_ff, period_in;
   logic [ptst_pkg::PERIOD_W-1:0]  count_ff, count_in;
   logic [ptst_pkg::PERIOD_W-1:0]  count_inc;

   assign count_inc = count_ff + ptst_pkg::PERIOD_W'(1);

   always_comb begin
      active_in  = active_ff;
      tag_in     = tag_ff;
      handler_in = handler_ff;
      period_in  = period_ff;
      count_in   = count_ff;
      tok_next   = tok_ff;
      emit_valid = 1'b0;
      emit_res   = '0;
      emit_res.slot = ptst_pkg::SLOT_W'(INDEX);
      if (tok_ff.valid) begin
         case (tok_ff.func)
            ptst_pkg::FUNC_REGISTER: begin
               if (!tok_ff.done && !active_ff) begin
                  active_in     = 1'b1;
                  tag_in        = tok_ff.tag;
                  handler_in    = tok_ff.handler;
                  period_in     = tok_ff.period;
                  count_in      = '0;
                  tok_next.done = 1'b1;
                  emit_valid    = 1'b1;
                  emit_res.kind = ptst_pkg::KIND_REGISTERED;
               end
            end
            ptst_pkg::FUNC_UNREGISTER: begin
               if (!tok_ff.done && active_ff && tag_ff == tok_ff.tag &&
                   handler_ff == tok_ff.handler) begin
                  active_in     = 1'b0;
                  tag_in        = ptst_pkg::FREED_TAG;
                  handler_in    = '0;
                  period_in     = '0;
                  count_in      = '0;
                  tok_next.done = 1'b1;
                  emit_valid    = 1'b1;
                  emit_res.kind = ptst_pkg::KIND_UNREGISTERED;
               end
            end
            ptst_pkg::FUNC_TICK: begin
               if (active_ff) begin
                  if (count_inc >= period_ff) begin
                     count_in = '0;
                     if (tok_ff.reported < ptst_pkg::REPORT_MAX) begin
                        tok_next.reported = tok_ff.reported + ptst_pkg::REPORT_W'(1);
                        tok_next.done     = 1'b1;
                        emit_valid        = 1'b1;
                        emit_res.kind     = ptst_pkg::KIND_EXPIRY;
                        emit_res.tag      = tag_ff;
                        emit_res.handler  = handler_ff;
                     end
                  end else begin
                     count_in = count_inc;
                  end
               end
            end
            default: begin
               tok_next = tok_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= '0;
         active_ff <= 1'b0;
      end else if (advance) begin
         tok_ff    <= tok_prev;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff     <= tag_in;
         handler_ff <= handler_in;
         period_ff  <= period_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the periodic timer slot table core.
import ptst_pkg::*;

typedef struct packed {
   kind_type      kind;
   logic [3:0]    slot;
   logic [7:0]    tag;
   logic [7:0]    handler;
   logic          last;
} timer_result_type;

class timer_table_scoreboard;
   logic [15:0]   default_period;
   bit            slot_active [SLOTS_DEFAULT];
   logic [7:0]    slot_tag [SLOTS_DEFAULT];
   logic [7:0]    slot_handler [SLOTS_DEFAULT];
   logic [15:0]   slot_period [SLOTS_DEFAULT];
   logic [15:0]   slot_count [SLOTS_DEFAULT];
   timer_result_type expected_results [$];
   int            errors;

   function new();
      default_period = DEFAULT_PERIOD_RESET;
      errors = 0;
      for (int i = 0; i < SLOTS_DEFAULT; i++) begin
         slot_active[i] = 1'b0;
         slot_tag[i] = 8'd0;
         slot_handler[i] = 8'd0;
         slot_period[i] = 16'd0;
         slot_count[i] = 16'd0;
      end
   endfunction

   function void push_result(kind_type kind, int slot, logic [7:0] tag, logic [7:0] handler,
                             bit last);
      timer_result_type item;
      item.kind = kind;
      item.slot = slot[3:0];
      item.tag = tag;
      item.handler = handler;
      item.last = last;
      expected_results.push_back(item);
   endfunction

   function int pick_active();
      int cand [$];
      for (int i = 0; i < SLOTS_DEFAULT; i++)
         if (slot_active[i]) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   // Updates the table for one accepted request and queues the responses it causes.
   function void note_request(logic [1:0] func, logic [7:0] tag, logic [7:0] handler,
                              logic [15:0] period);
      int found;
      int n;
      int hit_slot [SLOTS_DEFAULT];
      found = -1;
      n = 0;
      case (func)
         FUNC_REGISTER: begin
            for (int i = 0; i < SLOTS_DEFAULT; i++)
               if (!slot_active[i] && found < 0) found = i;
            if (found >= 0) begin
               slot_active[found] = 1'b1;
               slot_tag[found] = tag;
               slot_handler[found] = handler;
               slot_period[found] = (period == 16'd0) ? default_period : period;
               slot_count[found] = 16'd0;
               push_result(KIND_REGISTERED, found, 8'd0, 8'd0, 1'b1);
            end else begin
               push_result(KIND_FULL, 0, 8'd0, 8'd0, 1'b1);
            end
         end
         FUNC_UNREGISTER: begin
            for (int i = 0; i < SLOTS_DEFAULT; i++)
               if (slot_active[i] && slot_tag[i] == tag && slot_handler[i] == handler
                   && found < 0)
                  found = i;
            if (found >= 0) begin
               slot_active[found] = 1'b0;
               slot_tag[found] = FREED_TAG;
               slot_handler[found] = 8'd0;
               slot_period[found] = 16'd0;
               slot_count[found] = 16'd0;
               push_result(KIND_UNREGISTERED, found, 8'd0, 8'd0, 1'b1);
            end else begin
               push_result(KIND_NO_MATCH, 0, 8'd0, 8'd0, 1'b1);
            end
         end
         FUNC_TICK: begin
            for (int i = 0; i < SLOTS_DEFAULT; i++) begin
               if (slot_active[i]) begin
                  slot_count[i] = slot_count[i] + 16'd1;
                  if (slot_count[i] >= slot_period[i]) begin
                     slot_count[i] = 16'd0;
                     if (n < REPORT_MAX) begin
                        hit_slot[n] = i;
                        n++;
                     end
                  end
               end
            end
            if (n == 0)
               push_result(KIND_NO_EXPIRY, 0, 8'd0, 8'd0, 1'b1);
            for (int j = 0; j < n; j++)
               push_result(KIND_EXPIRY, hit_slot[j], slot_tag[hit_slot[j]],
                           slot_handler[hit_slot[j]], j == n - 1);
         end
         default: ;
      endcase
   endfunction

   task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch: %s", what);
   endtask

   task check_result(logic [2:0] kind, logic [3:0] slot, logic [7:0] tag, logic [7:0] handler,
                     logic last);
      timer_result_type want;
      if (expected_results.size() == 0) begin
         report($sformatf("unexpected response kind %0d slot %0d", kind, slot));
         return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind)
         report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (slot !== want.slot)
         report($sformatf("slot %0d, expected %0d", slot, want.slot));
      if (tag !== want.tag)
         report($sformatf("tag %0h, expected %0h", tag, want.tag));
      if (handler !== want.handler)
         report($sformatf("handler %0h, expected %0h", handler, want.handler));
      if (last !== want.last)
         report($sformatf("last %0b, expected %0b", last, want.last));
   endtask
endclass

module testbench;
   localparam int SLOTS = SLOTS_DEFAULT;
   localparam int SETTLE = 2 * SLOTS + 8;
   localparam int LIMIT = 400000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_wen = 1'b0;
   logic [PERIOD_W-1:0]     csr_wdata = '0;

   bit                      idle_on = 1'b1;
   int                      stall_left = 0;
   int                      cycle_count = 0;
   timer_table_scoreboard   sb;

   periodic_timer_slot_table_core #(
      .SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_result(rsp_tdata[2:0], rsp_tdata[6:3], rsp_tdata[14:7], rsp_tdata[22:15],
                         rsp_tlast);
   end

   // The request valid stays high from one request to the next unless a gap is taken.
   task automatic send_request(logic [1:0] func, logic [7:0] tag, logic [7:0] handler,
                               logic [15:0] period);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, period, handler, tag, func};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_request(func, tag, handler, period);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_default_period(logic [15:0] value);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      sb.default_period = value;
   endtask

   task automatic random_request();
      int pick;
      int idx;
      int shape;
      logic [7:0] tag;
      logic [7:0] handler;
      logic [15:0] period;
      pick = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      tag = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      handler = $urandom_range(0, 1) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(1, 255));
      if (shape < 60) period = 16'($urandom_range(1, 6));
      else if (shape < 75) period = 16'd0;
      else if (shape < 90) period = 16'($urandom_range(7, 300));
      else period = 16'($urandom_range(0, 65535));
      if (pick < 36) begin
         send_request(FUNC_REGISTER, tag, handler, period);
      end else if (pick < 66) begin
         idx = sb.pick_active();
         if (idx >= 0 && $urandom_range(0, 4) != 0)
            send_request(FUNC_UNREGISTER, sb.slot_tag[idx], sb.slot_handler[idx], period);
         else
            send_request(FUNC_UNREGISTER, tag, handler, period);
      end else if (pick < 98) begin
         send_request(FUNC_TICK, tag, handler, period);
      end else begin
         send_request(FUNC_UNUSED, tag, handler, period);
      end
   endtask

   initial begin
      logic [15:0] phase_period [5];
      sb = new();
      phase_period[0] = 16'd1;
      phase_period[1] = 16'hFFFF;
      phase_period[2] = 16'($urandom_range(2, 65534));
      phase_period[3] = DEFAULT_PERIOD_RESET;
      phase_period[4] = 16'($urandom_range(1, 8));
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_request(FUNC_TICK, 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_UNREGISTER, 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_REGISTER, 8'h00, 8'h00, 16'd1);
      send_request(FUNC_REGISTER, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(FUNC_REGISTER, 8'hA5, 8'h5A, 16'd0);
      send_request(FUNC_REGISTER, 8'h3C, 8'h00, 16'd2);
      send_request(FUNC_TICK, 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_TICK, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(FUNC_UNREGISTER, 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_UNREGISTER, 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(FUNC_REGISTER, 8'h11, 8'h01, 16'd3);
      send_request(FUNC_UNREGISTER, 8'hFF, 8'h01, 16'h0000);

      // With a zero default period the remaining slots expire on every tick.
      wait_drained();
      write_default_period(16'd0);
      for (int i = 0; i < 12; i++)
         send_request(FUNC_REGISTER, 8'(8'h40 + i), 8'(8'h80 + i), 16'd0);
      send_request(FUNC_REGISTER, 8'h77, 8'h77, 16'd9);
      send_request(FUNC_TICK, 8'h00, 8'h00, 16'h0000);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         idle_on = (p != 4);
         write_default_period(phase_period[p]);
         for (int i = 0; i < 71; i++)
            random_request();
      end

      wait_drained();
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
